/* rtl/deq_pkg.sv */
// Shared types, codes and sizes for the double-ended queue.
package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_CNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_GREATEST   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] VALUE_NONE = '1;
    localparam logic signed [DATA_W-1:0] VALUE_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_CNT_W-1:0]   entry_count;
    } t_out_item;

    // Operation broadcast to every cell; at most one strobe is high.
    typedef struct packed {
        logic                     push_back;
        logic                     push_front;
        logic                     pop_front;
        logic                     pop_back;
        logic                     clear;
        logic signed [DATA_W-1:0] data;
    } t_cell_cmd;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pmax;
    } t_link;

endpackage

/* rtl/deq_cell.sv */
// One queue cell: an entry, its occupancy bit and a running greatest value.
module deq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  deq_pkg::t_cell_cmd                 i_cmd,
    input  deq_pkg::t_link                     i_left,
    input  deq_pkg::t_link                     i_right,
    output deq_pkg::t_link                     o_link,
    output logic signed [deq_pkg::DATA_W-1:0]  o_tail
);

    logic                              r_occ;
    logic                              n_occ;
    logic signed [deq_pkg::DATA_W-1:0] r_val;
    logic signed [deq_pkg::DATA_W-1:0] n_val;
    logic signed [deq_pkg::DATA_W-1:0] r_pmax;
    logic signed [deq_pkg::DATA_W-1:0] n_pmax;

    always_comb begin
        n_occ = r_occ;
        n_val = r_val;
        if (i_cmd.clear) begin
            n_occ = 1'b0;
        end else if (i_cmd.push_front) begin
            n_occ = i_left.occ;
            n_val = i_left.val;
        end else if (i_cmd.push_back) begin
            // first free cell takes the item
            if (!r_occ && i_left.occ) begin
                n_occ = 1'b1;
                n_val = i_cmd.data;
            end
        end else if (i_cmd.pop_front) begin
            n_occ = i_right.occ;
            n_val = i_right.val;
        end else if (i_cmd.pop_back) begin
            if (r_occ && !i_right.occ) begin
                n_occ = 1'b0;
            end
        end
    end

    // Running maximum moves one cell per cycle toward the back.
    assign n_pmax = (r_occ && (r_val > i_left.pmax)) ? r_val : i_left.pmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_pmax <= n_pmax;
    end

    assign o_link.occ  = r_occ;
    assign o_link.val  = r_val;
    assign o_link.pmax = r_pmax;
    assign o_tail      = (r_occ && !i_right.occ) ? r_val : '0;

endmodule

/* rtl/double_ended_queue.sv */
// Double-ended queue top level: request decode, count, result register and the cell row.
//
// A bounded deque of DEPTH signed 32-bit entries held in a row of cells, the front
// entry in the first cell. Pushes, pops, clear and unknown modes give their result
// on the next cycle; a new item is taken while that result waits, as long as the
// result register is free or being emptied. The greatest-value query reads a running
// maximum that moves one cell per cycle down the row: it answers like the other modes
// when the maximum has reached the last cell since the last push, pop or clear, and
// otherwise waits in a scan state, taking no new items, until it has. A pop or greatest on
// an empty queue answers -1 with status empty; a push to a full queue is dropped
// with status full; entry_count is the count after the item (low 5 bits).
module double_ended_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [deq_pkg::CNT_W-1:0]       r_count;
    logic [deq_pkg::CNT_W-1:0]       n_count;
    logic [deq_pkg::CNT_W-1:0]       r_quiet;
    logic [deq_pkg::CNT_W-1:0]       n_quiet;
    logic                            r_out_valid;
    logic                            n_out_valid;
    deq_pkg::t_out_item              r_out_item;
    deq_pkg::t_out_item              n_out_item;

    deq_pkg::t_cell_cmd              cmd;
    deq_pkg::t_link                  links [deq_pkg::DEPTH];
    deq_pkg::t_link                  left_end;
    deq_pkg::t_link                  right_end;
    logic signed [deq_pkg::DATA_W-1:0] tails [deq_pkg::DEPTH];
    logic signed [deq_pkg::DATA_W-1:0] back_val;

    logic accept;
    logic slot_free;
    logic full;
    logic empty;
    logic quiet_done;
    logic changed;
    logic emit;
    logic signed [deq_pkg::DATA_W-1:0] emit_val;
    logic [deq_pkg::STATUS_W-1:0]      emit_status;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty      = (r_count == '0);
    assign quiet_done = (r_quiet == deq_pkg::CNT_W'(deq_pkg::DEPTH));

    assign left_end.occ   = 1'b1;
    assign left_end.val   = i_in_item.data_value;
    assign left_end.pmax  = deq_pkg::VALUE_MIN;
    assign right_end.occ  = 1'b0;
    assign right_end.val  = '0;
    assign right_end.pmax = '0;

    for (genvar k = 0; k < deq_pkg::DEPTH; k++) begin : g_cell
        deq_pkg::t_link left_in;
        deq_pkg::t_link right_in;
        if (k == 0) begin : g_first
            assign left_in = left_end;
        end else begin : g_mid_l
            assign left_in = links[k-1];
        end
        if (k == deq_pkg::DEPTH - 1) begin : g_last
            assign right_in = right_end;
        end else begin : g_mid_r
            assign right_in = links[k+1];
        end
        deq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_left  (left_in),
            .i_right (right_in),
            .o_link  (links[k]),
            .o_tail  (tails[k])
        );
    end

    // Only the last occupied cell drives its value onto its tail; all other cells drive zero.
    always_comb begin
        back_val = '0;
        for (int k = 0; k < deq_pkg::DEPTH; k++) begin
            back_val = back_val | tails[k];
        end
    end

    always_comb begin
        cmd         = '0;
        cmd.data    = i_in_item.data_value;
        n_state     = r_state;
        n_count     = r_count;
        changed     = 1'b0;
        emit        = 1'b0;
        emit_val    = deq_pkg::VALUE_NONE;
        emit_status = deq_pkg::STATUS_OK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    emit = 1'b1;
                    case (i_in_item.mode)
                        deq_pkg::MODE_PUSH_BACK: begin
                            if (full) begin
                                emit_status = deq_pkg::STATUS_FULL;
                            end else begin
                                cmd.push_back = 1'b1;
                                n_count       = r_count + 1'b1;
                                changed       = 1'b1;
                            end
                        end
                        deq_pkg::MODE_PUSH_FRONT: begin
                            if (full) begin
                                emit_status = deq_pkg::STATUS_FULL;
                            end else begin
                                cmd.push_front = 1'b1;
                                n_count        = r_count + 1'b1;
                                changed        = 1'b1;
                            end
                        end
                        deq_pkg::MODE_POP_FRONT: begin
                            if (empty) begin
                                emit_status = deq_pkg::STATUS_EMPTY;
                            end else begin
                                emit_val      = links[0].val;
                                cmd.pop_front = 1'b1;
                                n_count       = r_count - 1'b1;
                                changed       = 1'b1;
                            end
                        end
                        deq_pkg::MODE_POP_BACK: begin
                            if (empty) begin
                                emit_status = deq_pkg::STATUS_EMPTY;
                            end else begin
                                emit_val     = back_val;
                                cmd.pop_back = 1'b1;
                                n_count      = r_count - 1'b1;
                                changed      = 1'b1;
                            end
                        end
                        deq_pkg::MODE_CLEAR: begin
                            cmd.clear = 1'b1;
                            n_count   = '0;
                            changed   = 1'b1;
                        end
                        deq_pkg::MODE_GREATEST: begin
                            if (empty) begin
                                emit_status = deq_pkg::STATUS_EMPTY;
                            end else if (quiet_done) begin
                                emit_val = links[deq_pkg::DEPTH-1].pmax;
                            end else begin
                                // hold until the running maximum reaches the last cell
                                emit    = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (quiet_done && slot_free) begin
                    emit     = 1'b1;
                    emit_val = links[deq_pkg::DEPTH-1].pmax;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (changed) begin
            n_quiet = '0;
        end else if (quiet_done) begin
            n_quiet = r_quiet;
        end else begin
            n_quiet = r_quiet + 1'b1;
        end
    end

    always_comb begin
        n_out_item              = r_out_item;
        n_out_item.result_value = emit_val;
        n_out_item.status       = emit_status;
        n_out_item.entry_count  = deq_pkg::ENTRY_CNT_W'(n_count);
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_quiet     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_quiet     <= n_quiet;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* tb/double_ended_queue_test.sv */
// Self-checking testbench for the double-ended queue: directed and random requests.
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 900;
    localparam int TAIL_CYCLES = DEPTH + 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_in_item  pending_reqs[$];
    t_out_item expected_results[$];

    // Shadow copy of the deque contents.
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    int shadow_front = 0;
    int shadow_count = 0;

    int in_gap = 0;
    int out_stall = 0;
    int reqs_accepted = 0;
    int results_checked = 0;
    int greatest_seen = 0;
    int empty_seen = 0;
    int full_seen = 0;
    int errors = 0;
    int cycle_count = 0;

    double_ended_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one request to the shadow deque and return the result it should give.
    function automatic t_out_item deque_apply(t_in_item req);
        t_out_item res;
        logic signed [DATA_W-1:0] best;
        int pos;
        res.result_value = VALUE_NONE;
        res.status = STATUS_OK;
        case (req.mode)
            MODE_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    shadow_ring[(shadow_front + shadow_count) % DEPTH] = req.data_value;
                    shadow_count++;
                end
            end
            MODE_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_front] = req.data_value;
                    shadow_count++;
                end
            end
            MODE_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.result_value = shadow_ring[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            MODE_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.result_value = shadow_ring[(shadow_front + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
            end
            MODE_CLEAR: begin
                shadow_count = 0;
                shadow_front = 0;
            end
            MODE_GREATEST: begin
                if (shadow_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    best = shadow_ring[shadow_front];
                    for (pos = 1; pos < shadow_count; pos++) begin
                        if (shadow_ring[(shadow_front + pos) % DEPTH] > best)
                            best = shadow_ring[(shadow_front + pos) % DEPTH];
                    end
                    res.result_value = best;
                end
            end
            default: ;
        endcase
        res.entry_count = ENTRY_CNT_W'(shadow_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (errors < 100)
            $display("MISMATCH at cycle %0d, result %0d: %s got %h want %h",
                     cycle_count, results_checked, what, got, want);
        errors++;
    endtask

    task automatic queue_req(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
        t_in_item req;
        req.mode = mode;
        req.data_value = value;
        pending_reqs.push_back(req);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: v = VALUE_MIN;
                1: v = ~VALUE_MIN;
                2: v = VALUE_NONE;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // Idle only away from the end of the run, and not in every stretch.
    function automatic logic idling_allowed();
        return pending_reqs.size() > 120 && ((reqs_accepted / 128) % 3) != 1;
    endfunction

    // Driver: present items from pending_reqs, predict each one as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                t_out_item want;
                want = deque_apply(in_item);
                expected_results.push_back(want);
                reqs_accepted++;
                if (in_item.mode == MODE_GREATEST) greatest_seen++;
                if (want.status == STATUS_EMPTY) empty_seen++;
                if (want.status == STATUS_FULL) full_seen++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_item <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    if (idling_allowed() && $urandom_range(0, 7) == 0)
                        in_gap <= $urandom_range(1, 15);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result side in bursts and check each result taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", out_item.result_value, '0);
                end else begin
                    t_out_item want;
                    want = expected_results.pop_front();
                    if (out_item.result_value !== want.result_value)
                        report_mismatch("result_value", out_item.result_value,
                                        want.result_value);
                    if (out_item.status !== want.status)
                        report_mismatch("status", DATA_W'(out_item.status),
                                        DATA_W'(want.status));
                    if (out_item.entry_count !== want.entry_count)
                        report_mismatch("entry_count", DATA_W'(out_item.entry_count),
                                        DATA_W'(want.entry_count));
                end
                results_checked++;
            end
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 7) == 0)
                    out_stall <= $urandom_range(1, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int phase_len;
        int roll;
        int made;

        // Empty queue, extremes, each mode, unknown modes, clear.
        queue_req(MODE_GREATEST, 32'sd7);
        queue_req(MODE_POP_FRONT, 32'sd0);
        queue_req(MODE_POP_BACK, 32'sd0);
        queue_req(MODE_PUSH_BACK, VALUE_MIN);
        queue_req(MODE_PUSH_FRONT, ~VALUE_MIN);
        queue_req(MODE_PUSH_BACK, VALUE_NONE);
        queue_req(MODE_PUSH_FRONT, '0);
        queue_req(MODE_GREATEST, '0);
        queue_req(MODE_POP_BACK, '0);
        queue_req(MODE_POP_FRONT, '0);
        queue_req(MODE_GREATEST, VALUE_NONE);
        queue_req(3'd6, 32'h5555_5555);
        queue_req(3'd7, 32'haaaa_aaaa);
        queue_req(MODE_POP_FRONT, '0);
        queue_req(MODE_GREATEST, '0);
        queue_req(MODE_POP_BACK, '0);
        queue_req(MODE_POP_BACK, '0);
        queue_req(MODE_PUSH_BACK, 32'haaaa_aaaa);
        queue_req(MODE_PUSH_FRONT, 32'h5555_5555);
        queue_req(MODE_CLEAR, VALUE_NONE);
        queue_req(MODE_GREATEST, '0);
        queue_req(MODE_POP_FRONT, '0);
        queue_req(MODE_PUSH_FRONT, VALUE_MIN);
        queue_req(MODE_GREATEST, '0);

        // Random phases that lean toward filling, draining or neither.
        made = 0;
        while (made < RANDOM_REQS) begin
            phase = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < (phase == 0 ? 70 : phase == 1 ? 20 : 40))
                    queue_req($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                              pick_value());
                else if (roll < (phase == 0 ? 85 : 75))
                    queue_req($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK,
                              pick_value());
                else if (roll < 96)
                    queue_req(MODE_GREATEST, pick_value());
                else if (roll < 98)
                    queue_req(MODE_CLEAR, pick_value());
                else
                    queue_req(MODE_W'($urandom_range(6, 7)), pick_value());
                made++;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d results for %0d requests in %0d cycles",
                 results_checked, reqs_accepted, cycle_count);
        $display("greatest queries %0d, empty answers %0d, full drops %0d, mismatches %0d",
                 greatest_seen, empty_seen, full_seen, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
